@@ sv/rotated_aabb_bounds_assert.svh @@
// Assertion macros for the rotated box bounds block
`ifndef ROTATED_AABB_BOUNDS_ASSERT_SVH
`define ROTATED_AABB_BOUNDS_ASSERT_SVH

// same-cycle implication
`define RAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rab assertion failed");

// next-cycle implication
`define RAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rab assertion failed");

`endif

@@ sv/rab_pkg.sv @@
package rab_pkg;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] ang_t;

    typedef struct packed {
        ang_t ax;
        ang_t ay;
        ang_t az;
        ang_t c;
        ang_t s;
    } rot_cfg_t;

    typedef enum logic [2:0] {
        REG_AXIS_X    = 3'd0,
        REG_AXIS_Y    = 3'd1,
        REG_AXIS_Z    = 3'd2,
        REG_COS_ANGLE = 3'd3,
        REG_SIN_ANGLE = 3'd4
    } reg_idx_t;

    localparam ang_t ANG_ONE = 16'sd16384;
    localparam int ROT_STAGES  = 6;
    localparam int HULL_STAGES = 2;
    localparam int LATENCY     = ROT_STAGES + HULL_STAGES;

endpackage

@@ sv/rab_rotator.sv @@
module rab_rotator
(
    input  logic              clk,
    input  logic              en,
    input  rab_pkg::rot_cfg_t cfg,
    input  rab_pkg::coord_t   p [3],
    output rab_pkg::coord_t   r [3]
);

    rab_pkg::ang_t a [3];

    // stage 1: raw products
    logic signed [47:0] m1_next [3];
    logic signed [47:0] m2_next [3];
    logic signed [47:0] dp_next [3];
    logic signed [47:0] cp_next [3];
    logic signed [47:0] m1_reg [3];
    logic signed [47:0] m2_reg [3];
    logic signed [47:0] dp_reg [3];
    logic signed [47:0] cp_reg [3];

    // stage 2: cross, dot, c*p truncated
    logic signed [48:0] crs_full [3];
    logic signed [49:0] dot_full;
    logic signed [34:0] cr_reg [3];
    logic signed [35:0] d_reg;
    logic signed [33:0] cpt2_reg [3];

    // stage 3
    logic signed [17:0] kc;
    logic signed [50:0] scr_next [3];
    logic signed [53:0] kp_next;
    logic signed [50:0] scr_reg [3];
    logic signed [53:0] kp_reg;
    logic signed [33:0] cpt3_reg [3];

    // stage 4
    logic signed [39:0] k_reg;
    logic signed [36:0] scrt4_reg [3];
    logic signed [33:0] cpt4_reg [3];

    // stage 5
    logic signed [55:0] ka_next [3];
    logic signed [55:0] ka_reg [3];
    logic signed [36:0] scrt5_reg [3];
    logic signed [33:0] cpt5_reg [3];

    // stage 6
    logic signed [43:0] sum [3];
    rab_pkg::coord_t    r_next [3];
    rab_pkg::coord_t    r_reg [3];

    assign a[0] = cfg.ax;
    assign a[1] = cfg.ay;
    assign a[2] = cfg.az;

    always_comb
    begin
        m1_next[0] = a[1] * p[2];
        m2_next[0] = a[2] * p[1];
        m1_next[1] = a[2] * p[0];
        m2_next[1] = a[0] * p[2];
        m1_next[2] = a[0] * p[1];
        m2_next[2] = a[1] * p[0];
        for (int i = 0; i < 3; i++)
        begin
            dp_next[i] = a[i] * p[i];
            cp_next[i] = cfg.c * p[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            crs_full[i] = m1_reg[i] - m2_reg[i];
        end
        dot_full = dp_reg[0] + dp_reg[1] + dp_reg[2];
    end

    always_comb
    begin
        kc = rab_pkg::ANG_ONE - cfg.c;
        kp_next = kc * d_reg;
        for (int i = 0; i < 3; i++)
        begin
            scr_next[i] = cfg.s * cr_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ka_next[i] = k_reg * a[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = cpt5_reg[i] + scrt5_reg[i] + $signed(ka_reg[i][55:14]);
            if (sum[i] > 44'sd2147483647)
                r_next[i] = 32'sh7FFF_FFFF;
            else if (sum[i] < -44'sd2147483648)
                r_next[i] = 32'sh8000_0000;
            else
                r_next[i] = sum[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]    <= m1_next[i];
                m2_reg[i]    <= m2_next[i];
                dp_reg[i]    <= dp_next[i];
                cp_reg[i]    <= cp_next[i];
                cr_reg[i]    <= crs_full[i][48:14];
                cpt2_reg[i]  <= cp_reg[i][47:14];
                scr_reg[i]   <= scr_next[i];
                cpt3_reg[i]  <= cpt2_reg[i];
                scrt4_reg[i] <= scr_reg[i][50:14];
                cpt4_reg[i]  <= cpt3_reg[i];
                ka_reg[i]    <= ka_next[i];
                scrt5_reg[i] <= scrt4_reg[i];
                cpt5_reg[i]  <= cpt4_reg[i];
                r_reg[i]     <= r_next[i];
            end
            d_reg  <= dot_full[49:14];
            kp_reg <= kp_next;
            k_reg  <= kp_reg[53:14];
        end
    end

    assign r = r_reg;

endmodule

@@ sv/rab_hull.sv @@
module rab_hull
(
    input  logic            clk,
    input  logic            en,
    input  logic            has_box,
    input  rab_pkg::coord_t pt [8][3],
    output rab_pkg::coord_t lo [3],
    output rab_pkg::coord_t hi [3]
);

    rab_pkg::coord_t l1 [3][4];
    rab_pkg::coord_t h1 [3][4];
    rab_pkg::coord_t lo_next [3][2];
    rab_pkg::coord_t hi_next [3][2];
    rab_pkg::coord_t lo_part_reg [3][2];
    rab_pkg::coord_t hi_part_reg [3][2];
    rab_pkg::coord_t lo_reg [3];
    rab_pkg::coord_t hi_reg [3];
    rab_pkg::coord_t lo_fin [3];
    rab_pkg::coord_t hi_fin [3];

    // eight down to two per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                l1[i][j] = (pt[2*j][i] < pt[2*j+1][i]) ? pt[2*j][i] : pt[2*j+1][i];
                h1[i][j] = (pt[2*j][i] > pt[2*j+1][i]) ? pt[2*j][i] : pt[2*j+1][i];
            end
            for (int j = 0; j < 2; j++)
            begin
                lo_next[i][j] = (l1[i][2*j] < l1[i][2*j+1]) ? l1[i][2*j] : l1[i][2*j+1];
                hi_next[i][j] = (h1[i][2*j] > h1[i][2*j+1]) ? h1[i][2*j] : h1[i][2*j+1];
            end
        end
    end

    // absent box reads as all zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!has_box)
            begin
                lo_fin[i] = '0;
                hi_fin[i] = '0;
            end
            else
            begin
                lo_fin[i] = (lo_part_reg[i][0] < lo_part_reg[i][1]) ?
                            lo_part_reg[i][0] : lo_part_reg[i][1];
                hi_fin[i] = (hi_part_reg[i][0] > hi_part_reg[i][1]) ?
                            hi_part_reg[i][0] : hi_part_reg[i][1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_part_reg <= lo_next;
            hi_part_reg <= hi_next;
            lo_reg      <= lo_fin;
            hi_reg      <= hi_fin;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

@@ sv/rotated_aabb_bounds.sv @@
// Rotated box bounds.
// Input channel: in_valid / in_stall carry one box word (has_bounds plus
// min and max corners, signed Q16.16). Output channel: out_valid / out_stall
// carry the hull of the box rotated about the configured axis.
// A word moves when valid is high and stall is low at a rising edge.
// All eight corners are rotated in parallel by eight pipelined rotators,
// each six register stages deep, followed by a two-stage min/max tree.
// One word per cycle is taken while no valid output word is held by out_stall.
// When out_stall holds a valid output word, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Absent boxes come out with box_valid low and all coordinates zero.
// Rotation registers are written by cfg_we / cfg_index / cfg_data and must
// only change while the pipeline is empty; unknown indexes are ignored.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// identity rotation about z.
module rotated_aabb_bounds
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 has_bounds,
    input  logic signed [31:0]   min_x,
    input  logic signed [31:0]   min_y,
    input  logic signed [31:0]   min_z,
    input  logic signed [31:0]   max_x,
    input  logic signed [31:0]   max_y,
    input  logic signed [31:0]   max_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 box_valid,
    output logic signed [31:0]   out_min_x,
    output logic signed [31:0]   out_min_y,
    output logic signed [31:0]   out_min_z,
    output logic signed [31:0]   out_max_x,
    output logic signed [31:0]   out_max_y,
    output logic signed [31:0]   out_max_z
);

    localparam int LAT = rab_pkg::LATENCY;
    localparam int ROT = rab_pkg::ROT_STAGES;

    rab_pkg::rot_cfg_t cfg_reg;
    logic              adv;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    flg_reg;
    rab_pkg::coord_t   lo_in [3];
    rab_pkg::coord_t   hi_in [3];
    rab_pkg::coord_t   corner [8][3];
    rab_pkg::coord_t   rot [8][3];
    rab_pkg::coord_t   lo [3];
    rab_pkg::coord_t   hi [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ax <= '0;
            cfg_reg.ay <= '0;
            cfg_reg.az <= rab_pkg::ANG_ONE;
            cfg_reg.c  <= rab_pkg::ANG_ONE;
            cfg_reg.s  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rab_pkg::REG_AXIS_X:    cfg_reg.ax <= cfg_data;
                rab_pkg::REG_AXIS_Y:    cfg_reg.ay <= cfg_data;
                rab_pkg::REG_AXIS_Z:    cfg_reg.az <= cfg_data;
                rab_pkg::REG_COS_ANGLE: cfg_reg.c  <= cfg_data;
                rab_pkg::REG_SIN_ANGLE: cfg_reg.s  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            flg_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
            flg_reg <= {flg_reg[LAT-2:0], has_bounds};
        end
    end

    assign lo_in[0] = min_x;
    assign lo_in[1] = min_y;
    assign lo_in[2] = min_z;
    assign hi_in[0] = max_x;
    assign hi_in[1] = max_y;
    assign hi_in[2] = max_z;

    // corner n takes axis i from max when bit i of n is set
    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                corner[n][i] = n[i] ? hi_in[i] : lo_in[i];
            end
        end
    end

    for (genvar n = 0; n < 8; n++)
    begin : g_rot
        rab_rotator u_rot
        (
            .clk (clk),
            .en  (adv),
            .cfg (cfg_reg),
            .p   (corner[n]),
            .r   (rot[n])
        );
    end

    rab_hull u_hull
    (
        .clk     (clk),
        .en      (adv),
        .has_box (flg_reg[ROT]),
        .pt      (rot),
        .lo      (lo),
        .hi      (hi)
    );

    assign out_valid = vld_reg[LAT-1];
    assign box_valid = flg_reg[LAT-1];
    assign out_min_x = lo[0];
    assign out_min_y = lo[1];
    assign out_min_z = lo[2];
    assign out_max_x = hi[0];
    assign out_max_y = hi[1];
    assign out_max_z = hi[2];

endmodule

@@ sv/rab_checker.sv @@
`include "rotated_aabb_bounds_assert.svh"

module rab_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 box_valid,
    input logic signed [31:0]   out_min_x,
    input logic signed [31:0]   out_min_y,
    input logic signed [31:0]   out_min_z,
    input logic signed [31:0]   out_max_x,
    input logic signed [31:0]   out_max_y,
    input logic signed [31:0]   out_max_z
);

    `RAB_ASSERT_NOW(a_absent_zero, clk, rst_n, out_valid && !box_valid, out_min_x == 0 && out_min_y == 0 && out_min_z == 0 && out_max_x == 0 && out_max_y == 0 && out_max_z == 0)

    `RAB_ASSERT_NOW(a_hull_order, clk, rst_n, out_valid && box_valid, out_min_x <= out_max_x && out_min_y <= out_max_y && out_min_z <= out_max_z)

    `RAB_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_valid || !out_stall, !in_stall)

    `RAB_ASSERT_NEXT(a_hold_word, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_min_x) && $stable(out_max_z))

endmodule

bind rotated_aabb_bounds rab_checker u_rab_checker (.*);

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      bv;
        rab_pkg::coord_t [0:2]     mn;
        rab_pkg::coord_t [0:2]     mx;
    } hull_t;

    typedef struct {
        logic                  has;
        rab_pkg::coord_t [0:2] lo;
        rab_pkg::coord_t [0:2] hi;
        logic                  typed;
        hull_t                 want;
    } box_row_t;

    localparam rab_pkg::coord_t CMAX = 32'sh7fffffff;
    localparam rab_pkg::coord_t CMIN = 32'sh80000000;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASES = 10;
    localparam int     PHASE_WORDS = 115;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [15:0]      cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic             has_bounds;
    rab_pkg::coord_t  min_x, min_y, min_z, max_x, max_y, max_z;
    logic             out_valid;
    logic             out_stall;
    logic             box_valid;
    rab_pkg::coord_t  out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z;

    rotated_aabb_bounds u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .has_bounds(has_bounds),
        .min_x(min_x), .min_y(min_y), .min_z(min_z),
        .max_x(max_x), .max_y(max_y), .max_z(max_z),
        .out_valid(out_valid), .out_stall(out_stall), .box_valid(box_valid),
        .out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
        .out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z)
    );

    rab_pkg::rot_cfg_t rot;
    hull_t    pending_hulls[$];
    int       errors = 0;
    int       words_sent = 0;
    int       words_checked = 0;
    int       cfg_writes = 0;
    int       cycles = 0;
    bit       quiet = 0;
    bit       hold_req = 0;

    initial
    begin
        clk = 0;
        forever
        begin
            #6 clk = ~clk;
            if (clk)
            begin
                cycles++;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("timeout after %0d cycles", cycles);
                    $display("tb_top NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic longint q14(longint x);
        return x >>> 14;
    endfunction

    // Rodrigues rotation of all eight corners, min/max hull, saturated
    function automatic hull_t rotated_hull(logic has, rab_pkg::coord_t [0:2] lo,
                                           rab_pkg::coord_t [0:2] hi);
        hull_t  h;
        longint a[3], p[3], cr[3], mnl[3], mxl[3];
        longint c, s, d, k, r;
        h = '0;
        if (!has)
            return h;
        a[0] = rot.ax;
        a[1] = rot.ay;
        a[2] = rot.az;
        c = rot.c;
        s = rot.s;
        for (int i = 0; i < 3; i++)
        begin
            mnl[i] = CMAX;
            mxl[i] = CMIN;
        end
        for (int n = 0; n < 8; n++)
        begin
            for (int i = 0; i < 3; i++)
                p[i] = ((n >> i) & 1) ? longint'(hi[i]) : longint'(lo[i]);
            cr[0] = q14(a[1] * p[2] - a[2] * p[1]);
            cr[1] = q14(a[2] * p[0] - a[0] * p[2]);
            cr[2] = q14(a[0] * p[1] - a[1] * p[0]);
            d = q14(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]);
            k = q14((longint'(rab_pkg::ANG_ONE) - c) * d);
            for (int i = 0; i < 3; i++)
            begin
                r = q14(c * p[i]) + q14(s * cr[i]) + q14(k * a[i]);
                if (r > longint'(CMAX))
                    r = CMAX;
                if (r < longint'(CMIN))
                    r = CMIN;
                if (r < mnl[i])
                    mnl[i] = r;
                if (r > mxl[i])
                    mxl[i] = r;
            end
        end
        h.bv = 1;
        for (int i = 0; i < 3; i++)
        begin
            h.mn[i] = rab_pkg::coord_t'(mnl[i]);
            h.mx[i] = rab_pkg::coord_t'(mxl[i]);
        end
        return h;
    endfunction

    function automatic rab_pkg::coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX - rab_pkg::coord_t'($urandom_range(0, 3));
            1: return CMIN + rab_pkg::coord_t'($urandom_range(0, 3));
            2, 3: return rab_pkg::coord_t'($urandom);
            default: return rab_pkg::coord_t'(int'($urandom_range(0, 32'h1fffff)) - 32'h100000);
        endcase
    endfunction

    function automatic rab_pkg::ang_t rand_ang();
        case ($urandom_range(0, 4))
            0: return rab_pkg::ang_t'($urandom);
            1: return 16'sh7fff;
            2: return 16'sh8000;
            default: return rab_pkg::ang_t'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // output side: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1;
                repeat (120) @(posedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic chk(string name, rab_pkg::coord_t want, rab_pkg::coord_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        hull_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hulls.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word, box_valid %0b", $time, box_valid);
            end
            else
            begin
                w = pending_hulls.pop_front();
                words_checked++;
                if (w.bv !== box_valid)
                begin
                    errors++;
                    $display("%0t: box_valid expected %0b got %0b", $time, w.bv, box_valid);
                end
                chk("out_min_x", w.mn[0], out_min_x);
                chk("out_min_y", w.mn[1], out_min_y);
                chk("out_min_z", w.mn[2], out_min_z);
                chk("out_max_x", w.mx[0], out_max_x);
                chk("out_max_y", w.mx[1], out_max_y);
                chk("out_max_z", w.mx[2], out_max_z);
            end
        end
    end

    // leaves in_valid high after acceptance; caller lowers it when idling
    task automatic send_box(logic has, rab_pkg::coord_t [0:2] lo, rab_pkg::coord_t [0:2] hi,
                            logic typed, hull_t want);
        hull_t h;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1;
        has_bounds <= has;
        min_x <= lo[0];
        min_y <= lo[1];
        min_z <= lo[2];
        max_x <= hi[0];
        max_y <= hi[1];
        max_z <= hi[2];
        h = rotated_hull(has, lo, hi);
        if (typed && h !== want)
            $display("note: typed expectation differs from prediction");
        do
            @(posedge clk);
        while (in_stall);
        pending_hulls.push_back(typed ? want : h);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_hulls.size() != 0)
            @(posedge clk);
        repeat (rab_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        cfg_writes++;
        case (idx)
            rab_pkg::REG_AXIS_X:    rot.ax = rab_pkg::ang_t'(val);
            rab_pkg::REG_AXIS_Y:    rot.ay = rab_pkg::ang_t'(val);
            rab_pkg::REG_AXIS_Z:    rot.az = rab_pkg::ang_t'(val);
            rab_pkg::REG_COS_ANGLE: rot.c  = rab_pkg::ang_t'(val);
            rab_pkg::REG_SIN_ANGLE: rot.s  = rab_pkg::ang_t'(val);
            default: ;
        endcase
    endtask

    task automatic load_rotation(rab_pkg::ang_t ax, rab_pkg::ang_t ay, rab_pkg::ang_t az,
                                 rab_pkg::ang_t c, rab_pkg::ang_t s);
        write_reg(rab_pkg::REG_AXIS_X, ax);
        write_reg(rab_pkg::REG_AXIS_Y, ay);
        write_reg(rab_pkg::REG_AXIS_Z, az);
        write_reg(rab_pkg::REG_COS_ANGLE, c);
        write_reg(rab_pkg::REG_SIN_ANGLE, s);
    endtask

    initial
    begin
        box_row_t              dir_tab[$];
        rab_pkg::coord_t [0:2] lo, hi;
        hull_t                 none;
        none = '0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        has_bounds = 0;
        {min_x, min_y, min_z, max_x, max_y, max_z} = '0;
        rot = '{ax: 16'sd0, ay: 16'sd0, az: rab_pkg::ANG_ONE, c: rab_pkg::ANG_ONE,
                s: 16'sd0};

        // identity rotation after reset: hull equals the corners as given
        dir_tab.push_back('{1'b0, '{CMAX, CMIN, 7}, '{CMIN, CMAX, -7}, 1'b1, none});
        dir_tab.push_back('{1'b1, '{0, 0, 0}, '{0, 0, 0}, 1'b1, '{1'b1, '{0, 0, 0}, '{0, 0, 0}}});
        dir_tab.push_back('{1'b1, '{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX}, 1'b1,
                           '{1'b1, '{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX}}});
        // min above max: hull is the swapped box
        dir_tab.push_back('{1'b1, '{CMAX, 5, -1}, '{CMIN, -5, -2}, 1'b1,
                           '{1'b1, '{CMIN, -5, -2}, '{CMAX, 5, -1}}});
        dir_tab.push_back('{1'b1, '{-65536, 131072, 1}, '{65536, 196608, 2}, 1'b1,
                           '{1'b1, '{-65536, 131072, 1}, '{65536, 196608, 2}}});
        dir_tab.push_back('{1'b0, '{0, 0, 0}, '{1, 1, 1}, 1'b1, none});
        dir_tab.push_back('{1'b1, '{32'sh55555555, 32'sh2aaaaaaa, -1}, '{32'sh55555555,
                           32'sh2aaaaaaa, -1}, 1'b0, none});

        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_box(dir_tab[i].has, dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].typed,
                     dir_tab[i].want);
        drain();

        // quarter turn about x, then odd axes and saturation at full scale
        load_rotation(rab_pkg::ANG_ONE, 16'sd0, 16'sd0, 16'sd0, rab_pkg::ANG_ONE);
        write_reg(3'd5, 16'hffff);
        write_reg(3'd7, 16'h1234);
        for (int i = 0; i < 6; i++)
        begin
            lo = '{CMIN >>> i, -(32'sd1 <<< (i * 5)), CMAX >>> (i * 2)};
            hi = '{CMAX >>> i, 32'sd1 <<< (i * 5), CMIN >>> (i * 2)};
            send_box(1'b1, lo, hi, 1'b0, none);
        end
        drain();
        load_rotation(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        for (int i = 0; i < 6; i++)
        begin
            lo = '{rand_coord(), rand_coord(), rand_coord()};
            hi = '{rand_coord(), rand_coord(), rand_coord()};
            send_box(1'b1, lo, hi, 1'b0, none);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                quiet = 1;
            case (ph % 3)
                0: load_rotation(rand_ang(), rand_ang(), rand_ang(), rand_ang(), rand_ang());
                1: load_rotation(16'sd0, rab_pkg::ANG_ONE, 16'sd0, 16'sd11585, -16'sd11585);
                default: load_rotation(-rab_pkg::ANG_ONE, 16'sd0, 16'sd0, -rab_pkg::ANG_ONE,
                                       16'sd0);
            endcase
            if (ph == 1)
                hold_req = 1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                lo = '{rand_coord(), rand_coord(), rand_coord()};
                hi = '{rand_coord(), rand_coord(), rand_coord()};
                send_box($urandom_range(0, 9) != 0, lo, hi, 1'b0, none);
            end
            drain();
        end

        $display("%0d box words sent, %0d hulls checked, %0d register writes over %0d phases",
                 words_sent, words_checked, cfg_writes, PHASES + 3);
        $display("covered absent boxes, swapped corners, full-scale saturation and stalls");
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
